// ===== src/ppp_pkg.sv =====
// Shared constants and types for the perspective point projection block.
// No dependencies; imported by every module of the block.
`default_nettype none
package ppp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Configuration register indexes
  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd6;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 64;

  // Quotient magnitude is clipped at 2^QLIM_LOG
  localparam int unsigned QLIM_LOG = 40;

  // Queue status towards the back end
  typedef struct packed {
    logic full;
    logic empty;
  } ppp_fifo_st_t;

  // Control travelling with each divider stage
  typedef struct packed {
    logic vld;
    logic side;
    logic neg;
  } ppp_ctl_t;

endpackage
`default_nettype wire

// ===== src/perspective_point_projection.sv =====
// Top level of the perspective point projection block.
// Depends on ppp_pkg, ppp_front, ppp_fifo, ppp_back (and ppp_div).
//
// Channel   Direction  Handshake                  Payload
// command   in         start_i, busy_o            point_x_i, point_y_i, point_z_i
// config    in         cfg_valid_i, cfg_ready_o   cfg_idx_i, cfg_data_i
// result    out        result_valid_o (strobe)    proj_col_o, proj_row_o,
//                                                 depth_zero_o, saturated_o
//
// One point is taken per cycle while busy_o is low; each result passes, after its
// transfer in, through three front stages, the queue read, and a divider
// that retires one quotient bit per stage (42 stages) plus clip and output.
// Reset is asynchronous and active low; configuration registers clear to 0.
// busy_o rises only if the queue fills; results cannot be held off.
`default_nettype none
module perspective_point_projection import ppp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [WORD_W-1:0]    point_x_i,
  input  wire logic [WORD_W-1:0]    point_y_i,
  input  wire logic [WORD_W-1:0]    point_z_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output logic                      result_valid_o,
  output logic [WORD_W-1:0]         proj_col_o,
  output logic [WORD_W-1:0]         proj_row_o,
  output logic                      depth_zero_o,
  output logic                      saturated_o
);

  localparam int unsigned PW = WORD_W + COORD_WIDTH;
  localparam int unsigned OW = WORD_W + FRAC_BITS;
  localparam int unsigned MW = ((PW > OW) ? PW : OW) + 2;
  localparam int unsigned EW = 3 * MW + 3;

  logic                     accept, push, pop;
  logic [EW-1:0]            entry, entry_q;
  logic signed [WORD_W-1:0] center_col, center_row;
  ppp_fifo_st_t             fifo_st;

  assign accept      = start_i && !busy_o;
  assign busy_o      = fifo_st.full;
  assign cfg_ready_o = 1'b1;

  ppp_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .MW(MW), .EW(EW)) u_front (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .point_x_i, .point_y_i, .point_z_i,
    .cfg_we_i(cfg_valid_i && cfg_ready_o),
    .cfg_idx_i, .cfg_data_i,
    .center_col_o(center_col), .center_row_o(center_row),
    .push_o(push), .entry_o(entry)
  );

  ppp_fifo #(.W(EW), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(entry),
    .pop_i(pop), .rdata_o(entry_q), .st_o(fifo_st)
  );

  ppp_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .MW(MW), .EW(EW)) u_back (
    .clk_i, .rst_ni,
    .fifo_st_i(fifo_st), .entry_i(entry_q),
    .center_col_i(center_col), .center_row_i(center_row),
    .pop_o(pop),
    .result_valid_o, .proj_col_o, .proj_row_o, .depth_zero_o, .saturated_o
  );

endmodule
`default_nettype wire

// ===== src/ppp_fifo.sv =====
// Short queue between front end and divider back end.
// Depends on ppp_pkg for the status struct.
`default_nettype none
module ppp_fifo import ppp_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      rdata_o,
  output ppp_fifo_st_t      st_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rdata_q;

  assign st_o.full  = (cnt_q == CW'(DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign rdata_o    = rdata_q;

  // Write entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  // Registered read on a transfer out
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[rptr_q];
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!st_o.full || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !st_o.empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire

// ===== src/ppp_front.sv =====
// Front end: configuration registers, input capture, dot products and
// depth classification. Depends on ppp_pkg.
`default_nettype none
module ppp_front import ppp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned MW          = 66,
  parameter int unsigned EW          = 3 * 66 + 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [WORD_W-1:0]    point_x_i,
  input  wire logic [WORD_W-1:0]    point_y_i,
  input  wire logic [WORD_W-1:0]    point_z_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output logic signed [WORD_W-1:0]  center_col_o,
  output logic signed [WORD_W-1:0]  center_row_o,
  output logic                      push_o,
  output logic [EW-1:0]             entry_o
);

  localparam int unsigned PW = WORD_W + COORD_WIDTH;

  logic [CFG_W-1:0] cfg_q [NUM_REGS];

  logic                          a_vld_q, b_vld_q, c_vld_q;
  logic signed [COORD_WIDTH-1:0] pt_q   [3];
  logic signed [PW-1:0]          prod_q [3][3];
  logic signed [WORD_W-1:0]      off_q  [3];
  logic signed [MW-1:0]          sum_q  [3];

  logic [MW-1:0] mag_u, mag_v, mag_h;
  logic          neg_u, neg_v, zero_h;

  // Hold configuration; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i <= REG_CENTER)) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign center_col_o = signed'(cfg_q[REG_CENTER][WORD_W-1:0]);
  assign center_row_o = signed'(cfg_q[REG_CENTER][CFG_W-1:WORD_W]);

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // Capture the point, low coordinate bits only
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pt_q[0] <= signed'(point_x_i[COORD_WIDTH-1:0]);
      pt_q[1] <= signed'(point_y_i[COORD_WIDTH-1:0]);
      pt_q[2] <= signed'(point_z_i[COORD_WIDTH-1:0]);
    end
  end

  // One multiplier per matrix entry, then the row sums
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [WORD_W-1:0] coef;
      assign coef = signed'(cfg_q[2*r + c/2][WORD_W*(c%2) +: WORD_W]);
      always_ff @(posedge clk_i) begin
        prod_q[r][c] <= PW'(coef) * PW'(pt_q[c]);
      end
    end
    always_ff @(posedge clk_i) begin
      off_q[r] <= signed'(cfg_q[2*r + 1][CFG_W-1:WORD_W]);
      sum_q[r] <= MW'(prod_q[r][0]) + MW'(prod_q[r][1]) + MW'(prod_q[r][2])
                + (MW'(off_q[r]) <<< FRAC_BITS);
    end
  end

  // Classify depth and split signs from magnitudes
  always_comb begin
    zero_h = (sum_q[2] == '0);
    neg_u  = sum_q[0][MW-1] ^ sum_q[2][MW-1];
    neg_v  = sum_q[1][MW-1] ^ sum_q[2][MW-1];
    mag_u  = sum_q[0][MW-1] ? MW'(-sum_q[0]) : MW'(sum_q[0]);
    mag_v  = sum_q[1][MW-1] ? MW'(-sum_q[1]) : MW'(sum_q[1]);
    mag_h  = sum_q[2][MW-1] ? MW'(-sum_q[2]) : MW'(sum_q[2]);
  end

  assign push_o  = c_vld_q;
  assign entry_o = {mag_u, mag_v, mag_h, neg_u, neg_v, zero_h};

endmodule
`default_nettype wire

// ===== src/ppp_div.sv =====
// One axis of the back end: pipelined restoring divider, one quotient bit
// per stage, then clip, centre offset and saturation. Depends on ppp_pkg.
`default_nettype none
module ppp_div import ppp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned MW          = 66
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    vld_i,
  input  wire logic                    side_i,
  input  wire logic                    neg_i,
  input  wire logic [MW-1:0]           num_i,
  input  wire logic [MW-1:0]           den_i,
  input  wire logic signed [WORD_W-1:0] center_i,
  output logic                         vld_o,
  output logic                         side_o,
  output logic signed [COORD_WIDTH-1:0] val_o,
  output logic                         sat_o
);

  localparam int unsigned NW   = MW + FRAC_BITS;
  localparam int unsigned NSTG = QLIM_LOG + 2;
  localparam int unsigned CMPW = MW + NSTG + 1;
  localparam int unsigned SW   = QLIM_LOG + 4;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  ppp_ctl_t          ctl_q [NSTG+1];
  logic [NW-1:0]     rem_q [NSTG+1];
  logic [MW-1:0]     den_q [NSTG+1];
  logic [NSTG-1:0]   quo_q [NSTG+1];

  logic [NSTG-1:0]       q;
  logic                  over;
  logic [QLIM_LOG:0]     mag;
  logic signed [SW-1:0]  sval, ssum;
  logic signed [COORD_WIDTH-1:0] val_d;
  logic                  sat_d;

  logic                          vld_q, side_q, sat_q;
  logic signed [COORD_WIDTH-1:0] val_q;

  // Load the first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= '{vld: vld_i, side: side_i, neg: neg_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {num_i, {FRAC_BITS{1'b0}}};
    den_q[0] <= den_i;
    quo_q[0] <= '0;
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam int unsigned SH = NSTG - 1 - k;
    logic [CMPW-1:0] dsh, rex;
    logic            ge;
    assign dsh = CMPW'(den_q[k]) << SH;
    assign rex = CMPW'(rem_q[k]);
    assign ge  = (rex >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? NW'(rex - dsh) : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_q[k] | (NSTG'(ge) << SH);
    end
  end

  // Clip the quotient, apply sign and centre, then saturate
  always_comb begin
    q    = quo_q[NSTG];
    over = q[NSTG-1] | (q[NSTG-2] & (|q[NSTG-3:0]));
    mag  = over ? {1'b1, {QLIM_LOG{1'b0}}} : q[QLIM_LOG:0];
    sval = ctl_q[NSTG].neg ? -SW'(mag) : SW'(mag);
    ssum = sval + SW'(center_i);
    if (ssum > MAXV) begin
      val_d = COORD_WIDTH'(MAXV);
      sat_d = 1'b1;
    end else if (ssum < MINV) begin
      val_d = COORD_WIDTH'(MINV);
      sat_d = 1'b1;
    end else begin
      val_d = COORD_WIDTH'(ssum);
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_q[NSTG].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= ctl_q[NSTG].side;
    val_q  <= val_d;
    sat_q  <= sat_d;
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign val_o  = val_q;
  assign sat_o  = sat_q;

endmodule
`default_nettype wire

// ===== src/ppp_back.sv =====
// Back end: drains the queue into two divider lanes and drives results.
// Depends on ppp_pkg and ppp_div.
`default_nettype none
module ppp_back import ppp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned MW          = 66,
  parameter int unsigned EW          = 3 * 66 + 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ppp_fifo_st_t             fifo_st_i,
  input  wire logic [EW-1:0]            entry_i,
  input  wire logic signed [WORD_W-1:0] center_col_i,
  input  wire logic signed [WORD_W-1:0] center_row_i,
  output logic                          pop_o,
  output logic                          result_valid_o,
  output logic [WORD_W-1:0]             proj_col_o,
  output logic [WORD_W-1:0]             proj_row_o,
  output logic                          depth_zero_o,
  output logic                          saturated_o
);

  logic          ent_vld_q;
  logic [MW-1:0] mag_u, mag_v, mag_h;
  logic          neg_u, neg_v, zero_h;

  logic                          col_vld, row_vld, col_side, row_side, col_sat, row_sat;
  logic signed [COORD_WIDTH-1:0] col_val, row_val;

  logic                    res_vld_q, zero_q, sat_q;
  logic [WORD_W-1:0]       col_q, row_q;

  // Drain the queue whenever it holds an entry
  assign pop_o = !fifo_st_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
    end else begin
      ent_vld_q <= pop_o;
    end
  end

  assign {mag_u, mag_v, mag_h, neg_u, neg_v, zero_h} = entry_i;

  ppp_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .MW(MW)) u_div_col (
    .clk_i, .rst_ni,
    .vld_i(ent_vld_q), .side_i(zero_h), .neg_i(neg_u),
    .num_i(mag_u), .den_i(mag_h), .center_i(center_col_i),
    .vld_o(col_vld), .side_o(col_side), .val_o(col_val), .sat_o(col_sat)
  );

  ppp_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .MW(MW)) u_div_row (
    .clk_i, .rst_ni,
    .vld_i(ent_vld_q), .side_i(zero_h), .neg_i(neg_v),
    .num_i(mag_v), .den_i(mag_h), .center_i(center_row_i),
    .vld_o(row_vld), .side_o(row_side), .val_o(row_val), .sat_o(row_sat)
  );

  // Register the result; zero depth forces zero coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= col_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= col_side;
    sat_q  <= col_side ? 1'b0 : (col_sat | row_sat);
    col_q  <= col_side ? '0 : WORD_W'(col_val);
    row_q  <= col_side ? '0 : WORD_W'(row_val);
  end

  assign result_valid_o = res_vld_q;
  assign proj_col_o     = col_q;
  assign proj_row_o     = row_q;
  assign depth_zero_o   = zero_q;
  assign saturated_o    = sat_q;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_vld == row_vld)
    else $error("divider lanes out of step");

  a_lanes_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_vld |-> (col_side == row_side))
    else $error("depth flag differs between lanes");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && depth_zero_o) |->
      (!saturated_o && proj_col_o == '0 && proj_row_o == '0))
    else $error("zero depth result not cleared");

endmodule
`default_nettype wire

// ===== dv/perspective_point_projection_tb.sv =====
// Self-checking testbench for perspective_point_projection: drives points and
// register writes, predicts each projection and compares every result strobe.
// Depends on ppp_pkg and the perspective_point_projection RTL.
`default_nettype none
module perspective_point_projection_tb import ppp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned STALL_LIMIT  = 5000;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [WORD_W-1:0]    x;
    logic [WORD_W-1:0]    y;
    logic [WORD_W-1:0]    z;
  } job_t;

  typedef struct {
    logic [WORD_W-1:0] col;
    logic [WORD_W-1:0] row;
    logic              dz;
    logic              sat;
  } proj_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [WORD_W-1:0]    point_x_i = '0;
  logic [WORD_W-1:0]    point_y_i = '0;
  logic [WORD_W-1:0]    point_z_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 result_valid_o;
  logic [WORD_W-1:0]    proj_col_o;
  logic [WORD_W-1:0]    proj_row_o;
  logic                 depth_zero_o;
  logic                 saturated_o;

  job_t        job_q[$];
  proj_t       proj_q[$];
  logic [63:0] matrix_regs[NUM_REGS];
  int          gap_cnt;
  int          quiet_cnt;
  int          stall_cnt;
  int          err_cnt;

  perspective_point_projection dut (.*);

  always #5 clk_i = ~clk_i;

  // Exact row sum at twice the fraction bits
  function automatic logic signed [127:0] row_dot(int r, logic [31:0] px, logic [31:0] py,
                                                  logic [31:0] pz);
    logic signed [127:0] a0, a1, a2, a3, p0, p1, p2;
    a0 = $signed(matrix_regs[2*r][31:0]);
    a1 = $signed(matrix_regs[2*r][63:32]);
    a2 = $signed(matrix_regs[2*r+1][31:0]);
    a3 = $signed(matrix_regs[2*r+1][63:32]);
    p0 = $signed(px);
    p1 = $signed(py);
    p2 = $signed(pz);
    return a0 * p0 + a1 * p1 + a2 * p2 + (a3 <<< FRAC_BITS_DEF);
  endfunction

  // Divide by depth, clip the quotient, add the centre and saturate
  function automatic logic [31:0] axis_coord(logic signed [127:0] num,
                                             logic signed [127:0] den,
                                             logic [31:0] centre, inout logic sat);
    logic              neg;
    logic [127:0]      nm, dm, q;
    logic signed [63:0] v;
    neg = num[127] ^ den[127];
    nm  = num[127] ? -num : num;
    dm  = den[127] ? -den : den;
    q   = (nm << FRAC_BITS_DEF) / dm;
    if (q > (128'd1 << QLIM_LOG)) q = 128'd1 << QLIM_LOG;
    v = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    v = v + $signed({{32{centre[31]}}, centre});
    if (v > 64'sh7fff_ffff) begin
      v   = 64'sh7fff_ffff;
      sat = 1'b1;
    end
    if (v < -64'sh8000_0000) begin
      v   = -64'sh8000_0000;
      sat = 1'b1;
    end
    return v[31:0];
  endfunction

  function automatic proj_t project_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    proj_t              res;
    logic signed [127:0] u, v, h;
    logic               sat;
    sat = 1'b0;
    u = row_dot(0, px, py, pz);
    v = row_dot(1, px, py, pz);
    h = row_dot(2, px, py, pz);
    if (h == 0) begin
      res = '{col: '0, row: '0, dz: 1'b1, sat: 1'b0};
    end else begin
      res.col = axis_coord(u, h, matrix_regs[REG_CENTER][31:0], sat);
      res.row = axis_coord(v, h, matrix_regs[REG_CENTER][63:32], sat);
      res.dz  = 1'b0;
      res.sat = sat;
    end
    return res;
  endfunction

  // Driver: one transfer at a time, register writes only once the pipe has drained
  always @(posedge clk_i or negedge rst_ni) begin
    logic  nstart, ncfg, active;
    job_t  j;
    if (!rst_ni) begin
      start_i     <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_cnt     = 0;
      quiet_cnt   = 0;
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
    end else begin
      nstart = start_i;
      ncfg   = cfg_valid_i;
      if (start_i && !busy_o) begin
        proj_q.push_back(project_point(point_x_i, point_y_i, point_z_i));
        nstart    = 1'b0;
        quiet_cnt = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_idx_i < NUM_REGS) matrix_regs[cfg_idx_i] = cfg_data_i;
        ncfg = 1'b0;
      end
      if (proj_q.size() != 0) quiet_cnt = 0;
      else if (quiet_cnt < DRAIN_CYCLES) quiet_cnt++;
      active = nstart || ncfg;
      if (!active && job_q.size() != 0) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (!job_q[0].is_cfg) begin
          j = job_q.pop_front();
          point_x_i <= j.x;
          point_y_i <= j.y;
          point_z_i <= j.z;
          nstart  = 1'b1;
          gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end else if (quiet_cnt >= DRAIN_CYCLES) begin
          j = job_q.pop_front();
          cfg_idx_i  <= j.idx;
          cfg_data_i <= j.data;
          ncfg = 1'b1;
        end
      end
      start_i     <= nstart;
      cfg_valid_i <= ncfg;
    end
  end

  // Monitor: compare each strobe with the oldest prediction; watch for stalls
  always @(posedge clk_i) begin
    proj_t e;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (proj_q.size() == 0) begin
          $error("unexpected result col %h row %h", proj_col_o, proj_row_o);
          err_cnt++;
        end else begin
          e = proj_q.pop_front();
          if (proj_col_o !== e.col) begin
            $error("proj_col expected %h actual %h", e.col, proj_col_o);
            err_cnt++;
          end
          if (proj_row_o !== e.row) begin
            $error("proj_row expected %h actual %h", e.row, proj_row_o);
            err_cnt++;
          end
          if (depth_zero_o !== e.dz) begin
            $error("depth_zero expected %b actual %b", e.dz, depth_zero_o);
            err_cnt++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, saturated_o);
            err_cnt++;
          end
        end
      end
      if (result_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      5: return $urandom();
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    job_t j;
    j = '{is_cfg: 1'b1, idx: idx, data: data, x: '0, y: '0, z: '0};
    job_q.push_back(j);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    job_t j;
    j = '{is_cfg: 1'b0, idx: '0, data: '0, x: x, y: y, z: z};
    job_q.push_back(j);
  endtask

  // Pinhole camera: focal length f, unit depth along z plus an offset
  task automatic add_pinhole(logic [31:0] f, logic [31:0] zoff, logic [63:0] centre);
    add_cfg(REG_ROW0_C01, {32'h0, f});
    add_cfg(REG_ROW0_C23, 64'h0);
    add_cfg(REG_ROW1_C01, {f, 32'h0});
    add_cfg(REG_ROW1_C23, 64'h0);
    add_cfg(REG_ROW2_C01, 64'h0);
    add_cfg(REG_ROW2_C23, {zoff, 32'h0001_0000});
    add_cfg(REG_CENTER, centre);
  endtask

  initial begin
    logic [31:0] zoff;
    logic        pin;
    err_cnt   = 0;
    stall_cnt = 0;

    // All registers at reset: every depth is zero
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    add_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // Directed pinhole set-up with extremes, zero and negative depth, huge quotient
    add_pinhole(32'h0100_0000, 32'h0, {32'h00f0_0000, 32'h0140_0000});
    add_cfg(3'd7, 64'hdead_beef_dead_beef);
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
    add_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
    add_point(32'h0001_0000, 32'hfffe_0000, 32'hfffc_0000);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    add_point(32'h0000_0001, 32'hffff_ffff, 32'h0100_0000);
    add_point(32'h0050_0000, 32'hffb0_0000, 32'h0010_0000);
    add_point(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff);

    // Extreme matrix everywhere
    for (int r = 0; r < NUM_REGS; r++) add_cfg(r[CFG_IDX_W-1:0], {32'h8000_0000, 32'h7fff_ffff});
    add_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    add_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // Random phases: pinhole-like or fully random matrices
    for (int ph = 0; ph < 8; ph++) begin
      pin  = ($urandom_range(0, 2) != 0);
      zoff = pick_word();
      if (pin) begin
        add_pinhole(pick_word(), zoff, {pick_word(), pick_word()});
      end else begin
        for (int r = 0; r < NUM_REGS; r++) add_cfg(r[CFG_IDX_W-1:0], {pick_word(), pick_word()});
      end
      if ($urandom_range(0, 3) == 0) add_cfg(3'd7, {$urandom(), $urandom()});
      for (int n = 0; n < 180; n++) begin
        case ($urandom_range(0, 19))
          0: add_point($urandom(), $urandom(), pin ? -zoff : 32'h0);
          1, 2, 3, 4, 5: add_point($urandom(), $urandom(), $urandom());
          default: add_point(pick_word(), pick_word(),
                             $signed($urandom_range(1, 32'h01ff_ffff)) *
                             (($urandom_range(0, 1) != 0) ? 1 : -1));
        endcase
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (job_q.size() != 0 || start_i || cfg_valid_i || proj_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && proj_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (proj_q.size() != 0) $error("%0d results never arrived", proj_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/ppp_pkg.sv
src/ppp_fifo.sv
src/ppp_front.sv
src/ppp_div.sv
src/ppp_back.sv
src/perspective_point_projection.sv
dv/perspective_point_projection_tb.sv
